// ===== hw/rtl/gtfe_pkg.sv =====
package gtfe_pkg;

   // fixed-point constants, Q.16 or Q.20 as noted
   localparam logic [15:0] K_CUBIC   = 16'd46887;    // 0.044715 in Q.20
   localparam logic [15:0] K_SQRT2PI = 16'd52290;    // 0.7978845608 in Q.16
   localparam logic [17:0] K_2LOG2E  = 18'd189096;   // 2*log2(e) in Q.16
   localparam logic [19:0] C0_NEG    = 20'd55456;    // -c0 in Q.20
   localparam logic [19:0] C1_POS    = 20'd1040524;  // c1 in Q.20
   localparam logic [23:0] U_CLAMP   = 24'd8388608;  // 8.0 in Q.20
   localparam logic [4:0]  N_MAX     = 5'd23;
   // above this magnitude |u| is clamped anyway
   localparam logic [12:0] AM_MAX    = 13'd8191;

   localparam int QW      = 21;   // quotient bits
   localparam int DW      = 45;   // divisor bits
   localparam int FIFO_AW = 2;

   typedef struct packed {
      logic signed [15:0] x_in;
      logic               last_in;
   } gtfe_req_type;

   typedef struct packed {
      logic signed [15:0] y_out;
      logic               last_out;
   } gtfe_rsp_type;

   // per-sample sideband carried along the pipes
   typedef struct packed {
      logic [15:0] a;
      logic        neg;
      logic        last;
   } gtfe_side_type;

   // word handed from the front to the back
   typedef struct packed {
      gtfe_side_type side;
      logic [23:0]   u;
   } gtfe_mid_type;

endpackage

// ===== hw/rtl/gtfe_front.sv =====
module gtfe_front import gtfe_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  gtfe_req_type  req_data,
   output logic          mid_valid,
   input  logic          mid_ready,
   output gtfe_mid_type  mid_data
);

   logic [6:0]    vld_ff;
   gtfe_side_type side_ff [0:6];
   logic [12:0]   am_ff [0:3];
   logic [25:0]   sq_ff;
   logic [38:0]   cube_ff;
   logic [54:0]   p4_ff;
   logic [25:0]   inner_ff;
   logic [41:0]   up_ff;
   logic [23:0]   u_ff;
   logic          adv;
   logic [15:0]   a_in;
   logic [12:0]   am_in;
   logic [54:0]   p4_rnd;
   logic [41:0]   up_rnd;
   logic [25:0]   u_full;

   // whole pipe moves when its tail is empty or taken
   assign adv       = !vld_ff[6] || mid_ready;
   assign req_ready = adv;

   // sign and magnitude of the sample
   assign a_in  = req_data.x_in[15] ? (~req_data.x_in + 16'd1) : req_data.x_in;
   assign am_in = (a_in > {3'b000, AM_MAX}) ? AM_MAX : a_in[12:0];

   // rounding of the cubic term and of |u|
   assign p4_rnd = p4_ff + (55'd1 << 29);
   assign up_rnd = up_ff + (42'd1 << 15);
   assign u_full = up_rnd[41:16];

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[5:0], req_valid};
      end
   end

   // datapath stages
   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= '{a: a_in, neg: req_data.x_in[15], last: req_data.last_in};
         for (int i = 1; i < 7; i++) side_ff[i] <= side_ff[i-1];
         am_ff[0] <= am_in;
         for (int i = 1; i < 4; i++) am_ff[i] <= am_ff[i-1];
         sq_ff    <= 26'(am_ff[0]) * 26'(am_ff[0]);
         cube_ff  <= 39'(sq_ff) * 39'(am_ff[1]);
         p4_ff    <= 55'(cube_ff) * 55'(K_CUBIC);
         inner_ff <= (26'(am_ff[3]) << 10) + 26'(p4_rnd[54:30]);
         up_ff    <= 42'(inner_ff) * 42'(K_SQRT2PI);
         u_ff     <= (u_full > 26'(U_CLAMP)) ? U_CLAMP : u_full[23:0];
      end
   end

   assign mid_valid     = vld_ff[6];
   assign mid_data.side = side_ff[6];
   assign mid_data.u    = u_ff;

endmodule

// ===== hw/rtl/gtfe_fifo.sv =====
module gtfe_fifo import gtfe_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  gtfe_mid_type in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output gtfe_mid_type out_data
);

   localparam int DEPTH = 1 << FIFO_AW;

   gtfe_mid_type       mem_ff [0:DEPTH-1];
   logic [FIFO_AW-1:0] wr_ff, rd_ff;
   logic [FIFO_AW:0]   cnt_ff;
   logic               push, pop;

   assign in_ready  = (cnt_ff != (FIFO_AW+1)'(DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = mem_ff[rd_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         if (push && !pop)      cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push) cnt_ff <= cnt_ff - 1'b1;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= in_data;
   end

endmodule

// ===== hw/rtl/gtfe_div.sv =====
module gtfe_div import gtfe_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            adv,
   input  logic            in_valid,
   input  logic [DW-1:0]   in_d,
   input  gtfe_side_type   in_side,
   output logic            out_valid,
   output logic [QW-1:0]   out_q,
   output gtfe_side_type   out_side
);

   // computes (2^41 + d/2) / d, one quotient bit per stage
   logic [QW:0]    vld_ff;
   logic [DW-1:0]  rem_ff  [0:QW];
   logic [DW-1:0]  d_ff    [0:QW];
   logic [QW-1:0]  nlow_ff [0:QW];
   logic [QW-1:0]  q_ff    [0:QW];
   gtfe_side_type  side_ff [0:QW];
   logic [43:0]    num;

   assign num = (44'd1 << 41) + 44'(in_d[DW-1:1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[QW-1:0], in_valid};
      end
   end

   // load stage: quotient is below 2^21, so the top bits start the remainder
   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0]  <= DW'(num[43:QW]);
         nlow_ff[0] <= num[QW-1:0];
         d_ff[0]    <= in_d;
         q_ff[0]    <= '0;
         side_ff[0] <= in_side;
      end
   end

   // restoring subtract stages
   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [DW:0] trial;
      logic        ge;
      assign trial = {rem_ff[k], nlow_ff[k][QW-1]};
      assign ge    = (trial >= {1'b0, d_ff[k]});
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k+1]  <= ge ? DW'(trial - {1'b0, d_ff[k]}) : trial[DW-1:0];
            nlow_ff[k+1] <= {nlow_ff[k][QW-2:0], 1'b0};
            d_ff[k+1]    <= d_ff[k];
            q_ff[k+1]    <= {q_ff[k][QW-2:0], ge};
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = vld_ff[QW];
   assign out_q     = q_ff[QW];
   assign out_side  = side_ff[QW];

endmodule

// ===== hw/rtl/gtfe_back.sv =====
module gtfe_back import gtfe_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         mid_valid,
   output logic         mid_ready,
   input  gtfe_mid_type mid_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output gtfe_rsp_type rsp_data
);

   logic [3:0]    pre_vld_ff;
   gtfe_side_type pre_side_ff [0:3];
   logic [41:0]   tp_ff;
   logic [4:0]    n2_ff, n3_ff;
   logic [19:0]   f2_ff;
   logic [39:0]   fp_ff;
   logic [DW-1:0] d_ff;
   logic [2:0]    post_vld_ff;
   gtfe_side_type post_side_ff [0:1];
   logic [21:0]   w_ff;
   logic [37:0]   prod_ff;
   gtfe_rsp_type  rsp_ff;
   logic          adv;
   logic [41:0]   tp_rnd;
   logic [25:0]   t;
   logic [39:0]   fp_rnd;
   logic [20:0]   m;
   logic [43:0]   e;
   logic          dv_valid;
   logic [QW-1:0] dv_q;
   gtfe_side_type dv_side;
   logic [20:0]   r;
   logic [38:0]   prod_rnd;
   logic [17:0]   mag;
   logic [15:0]   y;

   assign adv       = !post_vld_ff[2] || rsp_ready;
   assign mid_ready = adv;

   // exponent: integer part and fraction of t
   assign tp_rnd = tp_ff + (42'd1 << 15);
   assign t      = tp_rnd[41:16];
   // 2^frac by the linear polynomial, then scaled by 2^n
   assign fp_rnd = fp_ff + (40'd1 << 19);
   assign m      = 21'(21'd1048576 - 21'(C0_NEG)) + fp_rnd[39:20];
   assign e      = 44'(m) << n3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_vld_ff <= '0;
      end else if (adv) begin
         pre_vld_ff <= {pre_vld_ff[2:0], mid_valid};
      end
   end

   // front end of the back pipe, up to the divisor
   always_ff @(posedge clock) begin
      if (adv) begin
         pre_side_ff[0] <= mid_data.side;
         for (int i = 1; i < 4; i++) pre_side_ff[i] <= pre_side_ff[i-1];
         tp_ff <= 42'(mid_data.u) * 42'(K_2LOG2E);
         n2_ff <= (t[25:20] > 6'(N_MAX)) ? N_MAX : t[24:20];
         f2_ff <= t[19:0];
         fp_ff <= 40'(f2_ff) * 40'(C1_POS);
         n3_ff <= n2_ff;
         d_ff  <= DW'(e) + (DW'(1) << 20);
      end
   end

   gtfe_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (pre_vld_ff[3]),
      .in_d      (d_ff),
      .in_side   (pre_side_ff[3]),
      .out_valid (dv_valid),
      .out_q     (dv_q),
      .out_side  (dv_side)
   );

   // 2/(e+1) limited to one; weight is 1+th or 1-th
   assign r        = (dv_q > 21'd1048576) ? 21'd1048576 : dv_q;
   assign prod_rnd = 39'(prod_ff) + (39'd1 << 20);
   assign mag      = prod_rnd[38:21];
   assign y        = post_side_ff[1].neg ? (~mag[15:0] + 16'd1)
                   : ((mag > 18'd32767) ? 16'h7FFF : mag[15:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         post_vld_ff <= '0;
      end else if (adv) begin
         post_vld_ff <= {post_vld_ff[1:0], dv_valid};
      end
   end

   // final scaling and output register
   always_ff @(posedge clock) begin
      if (adv) begin
         post_side_ff[0] <= dv_side;
         post_side_ff[1] <= post_side_ff[0];
         w_ff    <= dv_side.neg ? 22'(r) : (22'd2097152 - 22'(r));
         prod_ff <= 38'(post_side_ff[0].a) * 38'(w_ff);
         rsp_ff  <= '{y_out: y, last_out: post_side_ff[1].last};
      end
   end

   assign rsp_valid = post_vld_ff[2];
   assign rsp_data  = rsp_ff;

endmodule

// ===== hw/rtl/gelu_tanh_fast_exp.sv =====
// GELU (tanh form) on signed Q6.10 samples, one word accepted per clock
// with a saturated Q6.10 result and the last flag carried alongside.
// The front pipe (7 stages) forms |u| from the cubic polynomial; a 4-deep
// queue separates it from the back pipe, which builds the fast exponent,
// divides for 2/(e+1) in a 21-stage restoring divider (one quotient bit per
// stage) and applies the final scaling. Throughput is one word per cycle;
// each side stalls only when its output is held.
module gelu_tanh_fast_exp import gtfe_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  gtfe_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output gtfe_rsp_type rsp_data
);

   logic         f_valid, f_ready;
   gtfe_mid_type f_data;
   logic         q_valid, q_ready;
   gtfe_mid_type q_data;

   gtfe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .mid_valid (f_valid),
      .mid_ready (f_ready),
      .mid_data  (f_data)
   );

   gtfe_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_data),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   gtfe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_valid (q_valid),
      .mid_ready (q_ready),
      .mid_data  (q_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hw/rtl/gtfe_checker.sv =====
module gtfe_checker import gtfe_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input gtfe_req_type req_data,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input gtfe_rsp_type rsp_data
);

   // a held result word stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // nothing comes out right after reset
   a_rst_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a negative result never falls below half the most negative sample
   a_neg_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.y_out[15] |-> rsp_data.y_out >= -16'sd16384)
      else $error("negative result out of range");

endmodule

bind gelu_tanh_fast_exp gtfe_checker u_gtfe_checker (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import gtfe_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   gtfe_req_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   gtfe_rsp_type rsp_data;

   gelu_tanh_fast_exp uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   gtfe_req_type pending_words[$];
   gtfe_rsp_type expected_gelu[$];
   int           send_idle_pct;
   int           recv_stall_pct;
   int           errors;
   longint       cycle_count;

   // fixed-point gelu, tanh form with the fast exponent
   function automatic gtfe_rsp_type gelu_predict(gtfe_req_type w);
      gtfe_rsp_type res;
      logic [63:0]  a, cube, cubic, inner, u, t, n, f, m, e, d, r, th, mag;
      logic         neg;
      longint       y;
      neg = w.x_in[15];
      a = neg ? (64'h10000 - {48'd0, w.x_in}) : {48'd0, w.x_in};
      cube = a * a * a;
      cubic = (cube * 64'd46887 + (64'd1 << 29)) >> 30;
      inner = (a << 10) + cubic;
      u = (inner * 64'd52290 + (64'd1 << 15)) >> 16;
      if (u > 64'd8388608)
         u = 64'd8388608;
      t = (u * 64'd189096 + (64'd1 << 15)) >> 16;
      n = t >> 20;
      f = t & 64'hFFFFF;
      if (n > 64'd23)
         n = 64'd23;
      m = 64'd1048576 - 64'd55456 + ((64'd1040524 * f + (64'd1 << 19)) >> 20);
      e = m << n;
      d = e + 64'd1048576;
      r = ((64'd1 << 41) + d / 2) / d;
      if (r > 64'd1048576)
         r = 64'd1048576;
      th = 64'd1048576 - r;
      if (!neg) begin
         mag = (a * (64'd1048576 + th) + 64'd1048576) >> 21;
         y = longint'(mag);
      end else begin
         mag = (a * (64'd1048576 - th) + 64'd1048576) >> 21;
         y = -longint'(mag);
      end
      if (y > 32767)
         y = 32767;
      if (y < -32768)
         y = -32768;
      res.y_out = y[15:0];
      res.last_out = w.last_in;
      return res;
   endfunction

   task automatic add_word(logic [15:0] x, logic l);
      gtfe_req_type w;
      w.x_in = x;
      w.last_in = l;
      pending_words.push_back(w);
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // driver: presents queued words, idles at random
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_gelu.push_back(gelu_predict(req_data));
         if (!req_valid || req_ready) begin
            if (pending_words.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               req_data  <= pending_words.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compares each result word with the oldest prediction
   always @(posedge clock) begin
      gtfe_rsp_type exp_w;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_gelu.size() == 0) begin
               $display("%0t: unexpected word y=%0d last=%0b", $time,
                        rsp_data.y_out, rsp_data.last_out);
               errors++;
            end else begin
               exp_w = expected_gelu.pop_front();
               if (exp_w.y_out !== rsp_data.y_out) begin
                  $display("%0t: y_out expected %0d actual %0d", $time,
                           exp_w.y_out, rsp_data.y_out);
                  errors++;
               end
               if (exp_w.last_out !== rsp_data.last_out) begin
                  $display("%0t: last_out expected %0b actual %0b", $time,
                           exp_w.last_out, rsp_data.last_out);
                  errors++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 400000) begin
         $display("** gelu_tanh_fast_exp: FAILED **");
         $finish;
      end
   end

   // stimulus and end of run
   initial begin
      int i, ph, tail;
      int idle_tab[4];
      int stall_tab[4];
      idle_tab  = '{0, 78, 0, 11};
      stall_tab = '{0, 0, 78, 11};
      errors = 0;
      cycle_count = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      rsp_ready = 1'b0;
      req_data = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: zero, extremes, near the clamp, small values
      add_word(16'h0000, 1'b0);
      add_word(16'h7FFF, 1'b1);
      add_word(16'h8000, 1'b0);
      add_word(16'h8001, 1'b1);
      add_word(16'h0001, 1'b0);
      add_word(16'hFFFF, 1'b0);
      add_word(16'h0400, 1'b0);
      add_word(16'hFC00, 1'b1);
      add_word(16'h1000, 1'b0);
      add_word(16'hF000, 1'b0);
      add_word(16'h1FFF, 1'b0);
      add_word(16'h2000, 1'b1);
      add_word(16'hE000, 1'b0);
      add_word(16'h5555, 1'b0);
      add_word(16'hAAAA, 1'b1);
      add_word(16'h0800, 1'b0);
      add_word(16'hF800, 1'b0);
      add_word(16'h0200, 1'b1);
      add_word(16'hFE00, 1'b0);
      add_word(16'h0C00, 1'b1);

      // random phases, mostly in the interesting range of about +-8
      for (ph = 0; ph < 4; ph++) begin
         send_idle_pct = idle_tab[ph];
         recv_stall_pct = stall_tab[ph];
         for (i = 0; i < 235; i++) begin
            if ($urandom_range(3, 0) == 0)
               add_word(16'($urandom_range(65535, 0)), 1'($urandom_range(1, 0)));
            else
               add_word(16'($signed($urandom_range(16383, 0)) - 8192),
                        1'($urandom_range(1, 0)));
         end
         while (pending_words.size() > 0 || req_valid || expected_gelu.size() > 0)
            @(posedge clock);
      end

      // drain a while for stray words
      send_idle_pct = 0;
      recv_stall_pct = 0;
      tail = 0;
      while (tail < 100) begin
         @(posedge clock);
         tail++;
      end
      if (errors == 0 && expected_gelu.size() == 0)
         $display("** gelu_tanh_fast_exp: PASSED **");
      else
         $display("** gelu_tanh_fast_exp: FAILED **");
      $finish;
   end

endmodule
